@@ design/soft_saturation_sigmoid_defines.svh @@
// assertion helpers shared by the checking code of the sigmoid block
`ifndef SOFT_SATURATION_SIGMOID_DEFINES_SVH
`define SOFT_SATURATION_SIGMOID_DEFINES_SVH

// same-cycle implication, consequent may carry its own delay
`define SSIG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define SSIG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

@@ design/ssig_pkg.sv @@
package ssig_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int SAMPLE_WIDTH_DEF  = 24;

  localparam int SAT_W  = 23;
  localparam int INV_W  = 24;
  localparam int CFG_W  = 24;
  localparam int TAB_W  = 25;
  localparam int FRAC_W = 16;
  localparam int T_FRAC = 24;

  // u carries 32 fraction bits, so 8.0 sits at bit 35
  localparam int POS_SHIFT = 35;
  localparam int FRAC_LSB  = POS_SHIFT - FRAC_W;

  localparam logic [TAB_W-1:0] T_ONE   = {1'b1, {T_FRAC{1'b0}}};
  localparam logic [SAT_W-1:0] SAT_RST = 23'd24576;
  localparam logic [INV_W-1:0] INV_RST = 24'd174763;

  typedef enum logic [0:0] {
    REG_SATURATION     = 1'b0,
    REG_INV_SATURATION = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic one;
  } ctl_t;

  // shift-subtract division, used only while building constant tables
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

@@ design/ssig_front.sv @@
module ssig_front import ssig_pkg::*; #(
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IXW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [SAMPLE_WIDTH-1:0] x,
  input  logic [INV_W-1:0]        inv_saturation,
  output ctl_t                    ctl,
  output logic [IXW-1:0]          idx,
  output logic [FRAC_W-1:0]       frac
);

  localparam int UW = SAMPLE_WIDTH + INV_W;
  localparam int PW = POS_SHIFT + IXW;

  ctl_t                    a_ctl;
  logic [SAMPLE_WIDTH-1:0] a_mag;
  ctl_t                    b_ctl;
  logic [UW-1:0]           b_u;
  logic [PW-1:0]           pos;
  logic                    b_one;

  // most negative input keeps its full magnitude as an unsigned value
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else begin
      a_ctl.valid <= in_valid;
      a_ctl.neg   <= x[SAMPLE_WIDTH-1];
      a_ctl.one   <= 1'b0;
    end
    a_mag <= x[SAMPLE_WIDTH-1] ? (~x + SAMPLE_WIDTH'(1)) : x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else begin
      b_ctl <= a_ctl;
    end
    b_u <= UW'(a_mag) * UW'(inv_saturation);
  end

  assign b_one = |b_u[UW-1:POS_SHIFT];
  assign pos   = PW'(b_u[POS_SHIFT-1:0]) * PW'(TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= b_ctl.valid;
      ctl.neg   <= b_ctl.neg;
      ctl.one   <= b_one;
    end
    idx  <= pos[PW-1:POS_SHIFT];
    frac <= pos[POS_SHIFT-1:FRAC_LSB];
  end

endmodule

@@ design/ssig_interp.sv @@
module ssig_interp import ssig_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IXW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl_in,
  input  logic [IXW-1:0]    idx,
  input  logic [FRAC_W-1:0] frac,
  output ctl_t              ctl_out,
  output logic [TAB_W-1:0]  t
);

  typedef logic [TAB_W-1:0] tab_t [TABLE_ENTRIES+1];

  // tanh(8k/N) in q0.24, built from r = exp(-16/N) and its powers in q2.30
  function automatic tab_t build_tab();
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    tab_t        tab;
    y    = udiv64(64'd16 << 30, 64'(TABLE_ENTRIES));
    term = 64'd1 << 30;
    r    = 64'd1 << 30;
    e    = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = (term * y + (64'd1 << 29)) >> 30;
      term = udiv64(term + 64'(k >> 1), 64'(k));
      if (k % 2 == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      num    = ((64'd1 << 30) - e) << 24;
      den    = (64'd1 << 30) + e;
      tab[k] = TAB_W'(udiv64(num + (den >> 1), den));
      e      = (e * r + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tab();

  localparam int PRW = TAB_W + FRAC_W;

  ctl_t              d_ctl;
  logic [TAB_W-1:0]  d_lo;
  logic [TAB_W-1:0]  d_hi;
  logic [FRAC_W-1:0] d_frac;
  logic [TAB_W-1:0]  diff;
  logic [PRW-1:0]    step;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else begin
      d_ctl <= ctl_in;
    end
    d_lo   <= TANH_TAB[idx];
    d_hi   <= TANH_TAB[idx + IXW'(1)];
    d_frac <= frac;
  end

  assign diff = (d_hi >= d_lo) ? (d_hi - d_lo) : '0;
  assign step = PRW'(diff) * PRW'(d_frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= d_ctl;
    end
    t <= d_ctl.one ? T_ONE : (d_lo + step[PRW-1:FRAC_W]);
  end

endmodule

@@ design/soft_saturation_sigmoid.sv @@
// channel   ports                                  direction  handshake
// request   start, busy, response_in               in         taken when start && !busy
// result    done, response_out                     out        one-cycle strobe, no back-pressure
// config    wr_en, wr_index, wr_data               in         written when wr_en is high
//
// seven register stages: sign/magnitude, reciprocal multiply, table position,
// table read, interpolation, scale multiply, round/clamp/sign
// a taken request moves through these stages in order and raises done at the end, one request per cycle
// busy is high only during rst; rst clears the valid bits and reloads the configuration registers
// nothing stalls: the pipeline moves every cycle and the result is never held
`include "soft_saturation_sigmoid_defines.svh"

module soft_saturation_sigmoid import ssig_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] response_in,
  output logic                           done,
  output logic signed [SAMPLE_WIDTH-1:0] response_out,
  input  logic                           wr_en,
  input  logic [0:0]                     wr_index,
  input  logic [CFG_W-1:0]               wr_data
);

  localparam int IXW      = $clog2(TABLE_ENTRIES + 1);
  localparam int PRW      = SAT_W + TAB_W;
  localparam int MW       = PRW + 1 - T_FRAC;
  localparam int CW       = (SAMPLE_WIDTH > MW) ? SAMPLE_WIDTH : MW;
  localparam int PIPE_LAT = 7;
  localparam logic [CW-1:0] M_MAX = CW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [SAT_W-1:0]        saturation;
  logic [INV_W-1:0]        inv_saturation;
  logic                    accept;
  ctl_t                    c_ctl;
  logic [IXW-1:0]          c_idx;
  logic [FRAC_W-1:0]       c_frac;
  ctl_t                    e_ctl;
  logic [TAB_W-1:0]        e_t;
  ctl_t                    f_ctl;
  logic [PRW-1:0]          f_prod;
  logic [PRW:0]            rsum;
  logic [CW-1:0]           m_ext;
  logic [SAMPLE_WIDTH-1:0] mag_out;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation     <= SAT_RST;
      inv_saturation <= INV_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_SATURATION:     saturation     <= wr_data[SAT_W-1:0];
        REG_INV_SATURATION: inv_saturation <= wr_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  ssig_front #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (accept),
    .x              (response_in),
    .inv_saturation (inv_saturation),
    .ctl            (c_ctl),
    .idx            (c_idx),
    .frac           (c_frac)
  );

  ssig_interp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_interp (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (c_ctl),
    .idx     (c_idx),
    .frac    (c_frac),
    .ctl_out (e_ctl),
    .t       (e_t)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ctl <= '0;
    end else begin
      f_ctl <= e_ctl;
    end
    f_prod <= PRW'(saturation) * PRW'(e_t);
  end

  // round half up back to q11.12, then clamp so the most negative code never shows
  assign rsum    = {1'b0, f_prod} + ((PRW + 1)'(1) << (T_FRAC - 1));
  assign m_ext   = CW'(rsum[PRW:T_FRAC]);
  assign mag_out = (m_ext > M_MAX) ? SAMPLE_WIDTH'(M_MAX) : SAMPLE_WIDTH'(m_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_ctl.valid;
    end
    response_out <= f_ctl.neg ? (~mag_out + SAMPLE_WIDTH'(1)) : mag_out;
  end

  `SSIG_ASSERT_IMP(a_latency, accept, ##PIPE_LAT done, "request did not produce a result")
  `SSIG_ASSERT_IMP(a_no_most_neg, done, (response_out != MOST_NEG), "most negative code produced")
  `SSIG_ASSERT_IMP(a_sign_kept, accept && !response_in[SAMPLE_WIDTH-1], ##PIPE_LAT !response_out[SAMPLE_WIDTH-1], "positive input gave negative result")
  `SSIG_ASSERT_NXT(a_zero_in, accept && (response_in == '0), ##(PIPE_LAT-1) (response_out == '0), "zero input gave nonzero result")

endmodule

@@ test/tb_top.sv @@
module tb_top import ssig_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PTS = TABLE_ENTRIES_DEF;
  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int LATENCY = 7;
  localparam int N_PHASES = 16;
  localparam int PHASE_ITEMS = 82;
  localparam logic [SW-1:0] MAX_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] MAX_NEG = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CFG_W-1:0] SAT_TOP = 24'd8388607;
  localparam logic [CFG_W-1:0] INV_TOP = 24'd16777215;

  typedef struct packed {
    logic [CFG_W-1:0] sat_word;
    logic [CFG_W-1:0] inv_word;
    logic signed [SW-1:0] sample;
    logic typed;
    logic signed [SW-1:0] want;
  } directed_row_t;

  typedef struct packed {
    int unsigned seq;
    logic signed [SW-1:0] val;
  } pending_out_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [SW-1:0] response_in;
  logic done;
  logic signed [SW-1:0] response_out;
  logic wr_en;
  logic [0:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  longint unsigned tanh_pts [0:N_PTS];
  logic [SAT_W-1:0] sat_cfg;
  logic [INV_W-1:0] inv_cfg;
  logic [CFG_W-1:0] cur_sat_word;
  logic [CFG_W-1:0] cur_inv_word;
  pending_out_t pending_out_q[$];
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_settings;

  directed_row_t directed_rows [20] = '{
    '{24'd24576, 24'd174763, 24'sd0, 1'b1, 24'sd0},
    '{24'd24576, 24'd174763, MAX_POS, 1'b1, 24'sd24576},
    '{24'd24576, 24'd174763, MAX_NEG, 1'b1, -24'sd24576},
    '{24'd24576, 24'd174763, 24'sd1, 1'b0, 24'sd0},
    '{24'd24576, 24'd174763, -24'sd1, 1'b0, 24'sd0},
    '{24'd24576, 24'd174763, 24'sd24576, 1'b0, 24'sd0},
    '{24'd24576, 24'd174763, -24'sd24576, 1'b0, 24'sd0},
    '{24'd24576, 24'd174763, 24'sd196608, 1'b0, 24'sd0},
    '{24'd24576, 24'd174763, 24'sd196607, 1'b0, 24'sd0},
    // saturation zero: everything collapses to zero
    '{24'd0, 24'd174763, MAX_POS, 1'b1, 24'sd0},
    '{24'd0, 24'd174763, MAX_NEG, 1'b1, 24'sd0},
    // reciprocal zero
    '{24'd24576, 24'd0, MAX_POS, 1'b1, 24'sd0},
    '{24'd24576, 24'd0, -24'sd12345, 1'b1, 24'sd0},
    '{SAT_TOP, 24'd1, MAX_POS, 1'b0, 24'sd0},
    '{SAT_TOP, INV_TOP, MAX_POS, 1'b1, 24'sd8388607},
    // most negative input never gives the most negative code
    '{SAT_TOP, INV_TOP, MAX_NEG, 1'b1, -24'sd8388607},
    '{SAT_TOP, INV_TOP, 24'sd1, 1'b0, 24'sd0},
    '{SAT_TOP, INV_TOP, -24'sd1, 1'b0, 24'sd0},
    '{24'd1, INV_TOP, MAX_POS, 1'b1, 24'sd1},
    '{24'd1, INV_TOP, MAX_NEG, 1'b1, -24'sd1}
  };

  soft_saturation_sigmoid dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .response_in(response_in),
    .done(done),
    .response_out(response_out),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tanh(8k/N) in Q0.24, built from exp(-16/N) by a rounded series
  function automatic void build_tanh_points();
    longint unsigned q30_one;
    longint unsigned y;
    longint unsigned term;
    longint unsigned r;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    q30_one = 64'd1 << 30;
    y = (64'd16 << 30) / N_PTS;
    term = q30_one;
    r = q30_one;
    e = q30_one;
    for (longint unsigned k = 1; k <= 24; k++) begin
      term = (term * y + (64'd1 << 29)) >> 30;
      term = (term + k / 2) / k;
      if (k[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k <= N_PTS; k++) begin
      num = (q30_one - e) << 24;
      den = q30_one + e;
      tanh_pts[k] = (num + den / 2) / den;
      e = (e * r + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic logic signed [SW-1:0] soft_saturate(logic signed [SW-1:0] x);
    logic neg;
    logic [SW-1:0] mag;
    longint unsigned u;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned t;
    longint unsigned m;
    logic [SW-1:0] m_bits;
    neg = x[SW-1];
    mag = neg ? (~x + 1'b1) : x;
    u = 64'(mag) * 64'(inv_cfg);
    if (u >= (64'd1 << POS_SHIFT)) begin
      t = 64'd1 << T_FRAC;
    end else begin
      pos = u * N_PTS;
      idx = pos >> POS_SHIFT;
      frac = (pos & ((64'd1 << POS_SHIFT) - 1)) >> FRAC_LSB;
      if (idx >= N_PTS) idx = N_PTS - 1;
      lo = tanh_pts[idx];
      hi = tanh_pts[idx + 1];
      t = lo + ((hi >= lo) ? (((hi - lo) * frac) >> FRAC_W) : 64'd0);
    end
    m = (64'(sat_cfg) * t + (64'd1 << 23)) >> T_FRAC;
    if (m > 64'(MAX_POS)) m = 64'(MAX_POS);
    m_bits = m[SW-1:0];
    return neg ? -$signed(m_bits) : $signed(m_bits);
  endfunction

  task automatic report_mismatch(string what, int unsigned seq, logic signed [SW-1:0] got,
                                 logic signed [SW-1:0] want);
    $display("[%0t] mismatch: %s, request %0d: response_out %0d, expected %0d",
             $realtime, what, seq, got, want);
    n_errors++;
  endtask

  // register writes happen only with the pipeline empty
  task automatic set_registers(logic [CFG_W-1:0] sat_word, logic [CFG_W-1:0] inv_word);
    start <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_SATURATION;
    wr_data <= sat_word;
    @(posedge clk);
    wr_index <= REG_INV_SATURATION;
    wr_data <= inv_word;
    @(posedge clk);
    wr_en <= 1'b0;
    sat_cfg = sat_word[SAT_W-1:0];
    inv_cfg = inv_word[INV_W-1:0];
    cur_sat_word = sat_word;
    cur_inv_word = inv_word;
    n_settings++;
  endtask

  // start stays high across back-to-back requests
  task automatic send_request(logic signed [SW-1:0] x, int gap, logic typed,
                              logic signed [SW-1:0] want);
    pending_out_t p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    response_in <= x;
    do @(posedge clk); while (busy);
    p.seq = n_sent;
    p.val = typed ? want : soft_saturate(x);
    pending_out_q.push_back(p);
    n_sent++;
  endtask

  always @(posedge clk) begin
    pending_out_t p;
    if (!rst && done) begin
      if (pending_out_q.size() == 0) begin
        report_mismatch("result with nothing pending", 0, response_out, '0);
      end else begin
        p = pending_out_q.pop_front();
        if (response_out !== p.val) report_mismatch("response_out", p.seq, response_out, p.val);
        n_checked++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] sat_w;
    logic [CFG_W-1:0] inv_w;
    logic [63:0] recip;
    logic [31:0] raw;
    logic signed [SW-1:0] x;
    logic quiet;
    int pick;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    response_in = '0;
    wr_en = 1'b0;
    wr_index = REG_SATURATION;
    wr_data = '0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    n_settings = 0;
    sat_cfg = SAT_RST;
    inv_cfg = INV_RST;
    cur_sat_word = 24'(SAT_RST);
    cur_inv_word = 24'(INV_RST);
    build_tanh_points();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].sat_word != cur_sat_word ||
          directed_rows[i].inv_word != cur_inv_word) begin
        set_registers(directed_rows[i].sat_word, directed_rows[i].inv_word);
      end
      send_request(directed_rows[i].sample, $urandom_range(0, 2), directed_rows[i].typed,
                   directed_rows[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) begin
        sat_w = 24'(SAT_RST);
        inv_w = 24'(INV_RST);
      end else begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: sat_w = 24'd1;
          1: sat_w = SAT_TOP;
          2, 3, 4: sat_w = 24'($urandom_range(256, 65535));
          default: sat_w = 24'($urandom_range(1, 8388607));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
          0: inv_w = INV_TOP;
          1, 2: inv_w = 24'($urandom_range(1, 16777215));
          3: inv_w = (ph == 5) ? 24'd0 : 24'd1;
          default: begin
            // consistent reciprocal: 2^32 / s in Q4.20
            recip = (64'd1 << 32) / 64'(sat_w);
            inv_w = (recip > 64'(INV_TOP)) ? INV_TOP : recip[CFG_W-1:0];
          end
        endcase
        // bit above the saturation width must be ignored
        sat_w[CFG_W-1] = $urandom_range(0, 1);
      end
      set_registers(sat_w, inv_w);
      quiet = (ph % 4 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        raw = $urandom;
        pick = $urandom_range(0, 9);
        case (pick)
          0: begin
            case ($urandom_range(0, 4))
              0: x = MAX_POS;
              1: x = MAX_NEG;
              2: x = '0;
              3: x = 24'sd1;
              default: x = -24'sd1;
            endcase
          end
          1, 2: x = raw[SW-1:0];
          default: x = $signed(raw[SW-1:0]) >>> $urandom_range(0, 20);
        endcase
        send_request(x, quiet ? 0 : $urandom_range(0, 7), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("covered %0d samples over %0d register settings, %0d results compared",
             n_sent, n_settings, n_checked);
    $display("settings included zero saturation, zero and full reciprocal, both range ends");
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
